### src/numeric_literal_parser_defines.svh
// ---------------------------------------------------------------------------
// Numeric literal parser assertion macros
// Shared concurrent assertion wrappers clocked on clk.
// ---------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_PARSER_DEFINES_SVH
`define NUMERIC_LITERAL_PARSER_DEFINES_SVH

// Check a property while out of reset
`define NLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define NLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/nlp_pkg.sv
// ---------------------------------------------------------------------------
// Numeric literal parser package
// Character codes, keyword tracker states and the running token state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlp_pkg;

  // Parse modes
  localparam logic MODE_VALUE = 1'b0;
  localparam logic MODE_TIME  = 1'b1;

  // Character codes (after folding to lower case)
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  // Digit code for a character that is no hex digit
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  // Largest value a value-mode literal may take
  localparam logic [15:0] VALUE_LIMIT = 16'hFFFF;

  // Progress through "true" and "false"
  typedef enum logic [3:0] {
    KW_START = 4'd0,
    KW_T     = 4'd1,
    KW_TR    = 4'd2,
    KW_TRU   = 4'd3,
    KW_TRUE  = 4'd4,
    KW_F     = 4'd5,
    KW_FA    = 4'd6,
    KW_FAL   = 4'd7,
    KW_FALS  = 4'd8,
    KW_FALSE = 4'd9,
    KW_DEAD  = 4'd10
  } kw_state_t;

  // Running readings of one token (character count travels separately)
  typedef struct packed {
    logic [7:0]  first_char;
    logic [15:0] binary_acc;
    logic        binary_ok;
    logic [31:0] decimal_acc;
    logic        decimal_ok;
    logic        decimal_big;
    logic [15:0] hex_acc;
    logic        hex_ok;
    kw_state_t   kw;
  } tok_state_t;

  localparam tok_state_t TOK_CLEAR = '{
    first_char:  8'h00,
    binary_acc:  16'h0000,
    binary_ok:   1'b1,
    decimal_acc: 32'h0000_0000,
    decimal_ok:  1'b1,
    decimal_big: 1'b0,
    hex_acc:     16'h0000,
    hex_ok:      1'b1,
    kw:          KW_START
  };

endpackage

### src/nlp_token_step.sv
// ---------------------------------------------------------------------------
// Numeric literal parser character step
// Folds one character and advances every running reading of the token.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_token_step
  import nlp_pkg::*;
#(
  parameter int BINARY_LEN = 16,
  parameter int CNT_W      = $clog2(BINARY_LEN + 2)
) (
  input  logic [7:0]       char_code,
  input  tok_state_t       tok_cur,
  input  logic [CNT_W-1:0] cnt_cur,
  output tok_state_t       tok_nxt,
  output logic [CNT_W-1:0] cnt_nxt
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BINARY_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [7:0]  ch;
  logic [4:0]  digit;
  logic        pos0;
  logic        pos1;
  logic [35:0] dec_prod;

  // Next keyword state for one folded character
  function automatic kw_state_t kw_next(kw_state_t st, logic [7:0] c);
    kw_state_t r;
    r = KW_DEAD;
    unique case (st)
      KW_START: begin
        if (c == CH_T) r = KW_T;
        else if (c == CH_F) r = KW_F;
      end
      KW_T:    if (c == CH_R) r = KW_TR;
      KW_TR:   if (c == CH_U) r = KW_TRU;
      KW_TRU:  if (c == CH_E) r = KW_TRUE;
      KW_F:    if (c == CH_A) r = KW_FA;
      KW_FA:   if (c == CH_L) r = KW_FAL;
      KW_FAL:  if (c == CH_S) r = KW_FALS;
      KW_FALS: if (c == CH_E) r = KW_FALSE;
      default: r = KW_DEAD;
    endcase
    return r;
  endfunction

  // Fold upper case letters and decode the digit value
  always_comb begin
    ch = ((char_code >= CH_UP_A) && (char_code <= CH_UP_Z)) ? char_code + CASE_GAP
                                                           : char_code;
    if ((ch >= CH_ZERO) && (ch <= CH_NINE)) digit = 5'(ch - CH_ZERO);
    else if ((ch >= CH_A) && (ch <= CH_F)) digit = 5'(ch - CH_A) + 5'd10;
    else digit = DIGIT_NONE;
  end

  assign pos0 = (cnt_cur == '0);
  assign pos1 = (cnt_cur == CNT_ONE);

  // Decimal product with headroom for the range check
  assign dec_prod = ({4'b0, tok_cur.decimal_acc} << 3) + ({4'b0, tok_cur.decimal_acc} << 1)
                  + {31'b0, digit};

  // Advance the readings
  always_comb begin
    tok_nxt = tok_cur;

    if (pos0) tok_nxt.first_char = ch;

    // Binary reading
    if (digit >= 5'd2) begin
      tok_nxt.binary_ok = 1'b0;
    end else begin
      if (tok_cur.binary_acc[15]) tok_nxt.binary_ok = 1'b0;
      tok_nxt.binary_acc = {tok_cur.binary_acc[14:0], digit[0]};
    end

    // Decimal reading, wraps at 32 bits
    if (digit >= 5'd10) begin
      tok_nxt.decimal_ok = 1'b0;
    end else begin
      if (dec_prod > {20'b0, VALUE_LIMIT}) tok_nxt.decimal_big = 1'b1;
      tok_nxt.decimal_acc = dec_prod[31:0];
    end

    // Hex reading after the prefix
    if (pos0) begin
      if ((ch != CH_DOLLAR) && (ch != CH_ZERO)) tok_nxt.hex_ok = 1'b0;
    end else if (pos1 && (tok_cur.first_char == CH_ZERO)) begin
      if (ch != CH_X) tok_nxt.hex_ok = 1'b0;
    end else if (digit >= DIGIT_NONE) begin
      tok_nxt.hex_ok = 1'b0;
    end else begin
      if (tok_cur.hex_acc[15:12] != 4'h0) tok_nxt.hex_ok = 1'b0;
      tok_nxt.hex_acc = {tok_cur.hex_acc[11:0], digit[3:0]};
    end

    tok_nxt.kw = kw_next(tok_cur.kw, ch);
  end

  // Count characters, saturating one past the binary length
  assign cnt_nxt = (cnt_cur < CNT_MAX) ? cnt_cur + CNT_ONE : cnt_cur;

endmodule

### src/nlp_finish.sv
// ---------------------------------------------------------------------------
// Numeric literal parser token finish
// Picks the reading that applies to a complete token and flags errors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_finish
  import nlp_pkg::*;
#(
  parameter int BINARY_LEN = 16,
  parameter int CNT_W      = $clog2(BINARY_LEN + 2)
) (
  input  logic             parse_mode,
  input  tok_state_t       tok,
  input  logic [CNT_W-1:0] len,
  output logic [31:0]      parsed_value,
  output logic             parse_error
);

  localparam logic [CNT_W-1:0] LEN_BIN = CNT_W'(BINARY_LEN);
  localparam logic [CNT_W-1:0] LEN_1   = CNT_W'(1);
  localparam logic [CNT_W-1:0] LEN_2   = CNT_W'(2);
  localparam logic [CNT_W-1:0] LEN_3   = CNT_W'(3);

  logic [31:0] val;
  logic        ok;

  // Select the reading in order of precedence
  always_comb begin
    if (parse_mode == MODE_TIME) begin
      val = tok.decimal_acc;
      ok  = tok.decimal_ok;
    end else begin
      priority if (len == LEN_BIN) begin
        val = {16'b0, tok.binary_acc};
        ok  = tok.binary_ok;
      end else if ((tok.kw == KW_T) || (tok.kw == KW_TRUE) ||
                   ((len == LEN_1) && (tok.first_char == CH_ONE))) begin
        val = 32'd1;
        ok  = 1'b1;
      end else if ((tok.kw == KW_F) || (tok.kw == KW_FALSE) ||
                   ((len == LEN_1) && (tok.first_char == CH_ZERO))) begin
        val = 32'd0;
        ok  = 1'b1;
      end else if (tok.first_char == CH_ZERO) begin
        val = {16'b0, tok.hex_acc};
        ok  = tok.hex_ok && (len >= LEN_3);
      end else if (tok.first_char == CH_DOLLAR) begin
        val = {16'b0, tok.hex_acc};
        ok  = tok.hex_ok && (len >= LEN_2);
      end else begin
        val = tok.decimal_acc;
        ok  = tok.decimal_ok && !tok.decimal_big;
      end
    end
  end

  // Zero the value on error
  assign parsed_value = ok ? val : 32'd0;
  assign parse_error  = !ok;

endmodule

### src/numeric_literal_parser.sv
// Numeric literal parser: reads a text token one character per request and
// returns one result for each token.
// Input stream: in_tdata carries a character, in_tlast marks the last one of
// the token. Letters are folded to lower case before parsing.
// Result stream: out_tdata carries the parsed value, out_tuser the error flag.
// Configuration: cfg_data selects value mode (0) or time mode (1); cfg_ready
// is always high and the mode is used when the token ends.
// Throughput: one character per cycle, back to back, while no token end waits
// on a stalled result; set by the single registered pass through the character
// step logic. Result path: the last character of a token passes the input
// register, then the result register, before its result shows on out_tvalid.
// Stall: while out_tready is low the result holds; characters that do not end
// a token keep flowing, and a token end waits in the input register.
// Reset: clears the pipeline, the token state and the mode (value mode).
// ---------------------------------------------------------------------------
// Numeric literal parser top level
// Input register, token state, finish logic and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "numeric_literal_parser_defines.svh"

module numeric_literal_parser
  import nlp_pkg::*;
#(
  parameter int BINARY_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] char_code
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  // out_tdata: [31:0] parsed_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tuser: [0] parse_error
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data
);

  localparam int CNT_W = $clog2(BINARY_LEN + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BINARY_LEN + 1);

  logic             mode_r;
  logic             s1_valid_r;
  logic [7:0]       s1_char_r;
  logic             s1_last_r;
  tok_state_t       tok_r;
  logic [CNT_W-1:0] cnt_r;
  tok_state_t       tok_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic [31:0]      out_value_r;
  logic             out_err_r;
  logic [31:0]      fin_value;
  logic             fin_error;
  logic             s1_adv;
  logic             s1_emit;

  // Move the held character on unless it ends a token and the result is stuck
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign s1_emit   = s1_adv && s1_last_r;
  assign in_tready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  // Hold the parse mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_VALUE;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data[0];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  nlp_token_step #(
    .BINARY_LEN (BINARY_LEN),
    .CNT_W      (CNT_W)
  ) u_step (
    .char_code (s1_char_r),
    .tok_cur   (tok_r),
    .cnt_cur   (cnt_r),
    .tok_nxt   (tok_nxt),
    .cnt_nxt   (cnt_nxt)
  );

  nlp_finish #(
    .BINARY_LEN (BINARY_LEN),
    .CNT_W      (CNT_W)
  ) u_finish (
    .parse_mode   (mode_r),
    .tok          (tok_nxt),
    .len          (cnt_nxt),
    .parsed_value (fin_value),
    .parse_error  (fin_error)
  );

  // Advance the token state, clear it at a token end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= TOK_CLEAR;
      cnt_r <= '0;
    end else if (s1_emit) begin
      tok_r <= TOK_CLEAR;
      cnt_r <= '0;
    end else if (s1_adv) begin
      tok_r <= tok_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_value_r <= fin_value;
      out_err_r   <= fin_error;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_err_r;

  // Checks
  `NLP_ASSERT(a_emit_gives_result, s1_emit |=> out_tvalid, "token end gave no result")
  `NLP_ASSERT(a_error_zero_value, (out_tvalid && out_tuser) |-> (out_tdata == 32'd0), "error result carries a value")
  `NLP_ASSERT(a_count_saturates, cnt_r <= CNT_MAX, "character count past saturation")
  `NLP_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!out_tvalid && !s1_valid_r && (cnt_r == '0)), "pipeline not empty after reset")

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Numeric literal parser testbench
// Streams text tokens one character per request into the parser and checks
// each result against a scoreboard that tracks the token readings itself.
// Starts with directed tokens, then runs random tokens under three
// back-pressure profiles, switching between value and time mode.
// ---------------------------------------------------------------------------

module tb;
  import nlp_pkg::*;

  localparam int BIN_LEN     = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CHUNK_CHARS = 66;

  typedef struct {
    bit [31:0] value;
    bit        error;
  } literal_result_t;

  // Scoreboard: follows the token state and queues the expected results
  class literal_scoreboard;
    bit                mode;
    bit [4:0]          count;
    bit [7:0]          first;
    bit [15:0]         bin_acc;
    bit                bin_ok;
    bit [31:0]         dec_acc;
    bit                dec_ok;
    bit                dec_big;
    bit [15:0]         hex_acc;
    bit                hex_ok;
    kw_state_t         kw;
    literal_result_t   results_q[$];
    int                errors;

    function new();
      mode   = MODE_VALUE;
      errors = 0;
      clear_token();
    endfunction

    function void clear_token();
      count   = 0;
      first   = 8'h00;
      bin_acc = 16'h0000;
      bin_ok  = 1'b1;
      dec_acc = 32'h0;
      dec_ok  = 1'b1;
      dec_big = 1'b0;
      hex_acc = 16'h0000;
      hex_ok  = 1'b1;
      kw      = KW_START;
    endfunction

    function void set_mode(bit m);
      mode = m;
    endfunction

    function int pending();
      return results_q.size();
    endfunction

    // Advance the readings by one accepted character
    function void note_char(bit [7:0] raw, bit last);
      bit [7:0]          c;
      bit [4:0]          d;
      bit [16:0]         nb;
      bit [19:0]         nh;
      longint unsigned   nd;
      literal_result_t   r;

      c = (raw >= CH_UP_A && raw <= CH_UP_Z) ? raw + CASE_GAP : raw;
      if (c >= CH_ZERO && c <= CH_NINE) d = 5'(c - CH_ZERO);
      else if (c >= CH_A && c <= CH_F) d = 5'(c - CH_A) + 5'd10;
      else d = DIGIT_NONE;

      if (count == 0) first = c;

      // binary reading
      if (d >= 2) begin
        bin_ok = 1'b0;
      end else begin
        nb = {bin_acc, d[0]};
        if (nb > VALUE_LIMIT) bin_ok = 1'b0;
        bin_acc = nb[15:0];
      end

      // decimal reading, wraps at 32 bits
      if (d >= 10) begin
        dec_ok = 1'b0;
      end else begin
        nd = dec_acc;
        nd = nd * 10 + d;
        if (nd > VALUE_LIMIT) dec_big = 1'b1;
        dec_acc = nd[31:0];
      end

      // hex reading after the prefix
      if (count == 0) begin
        if (c != CH_DOLLAR && c != CH_ZERO) hex_ok = 1'b0;
      end else if (count == 1 && first == CH_ZERO) begin
        if (c != CH_X) hex_ok = 1'b0;
      end else if (d >= DIGIT_NONE) begin
        hex_ok = 1'b0;
      end else begin
        nh = {hex_acc, d[3:0]};
        if (nh > VALUE_LIMIT) hex_ok = 1'b0;
        hex_acc = nh[15:0];
      end

      // keyword progress
      case (kw)
        KW_START: kw = (c == CH_T) ? KW_T : ((c == CH_F) ? KW_F : KW_DEAD);
        KW_T:     kw = (c == CH_R) ? KW_TR : KW_DEAD;
        KW_TR:    kw = (c == CH_U) ? KW_TRU : KW_DEAD;
        KW_TRU:   kw = (c == CH_E) ? KW_TRUE : KW_DEAD;
        KW_F:     kw = (c == CH_A) ? KW_FA : KW_DEAD;
        KW_FA:    kw = (c == CH_L) ? KW_FAL : KW_DEAD;
        KW_FAL:   kw = (c == CH_S) ? KW_FALS : KW_DEAD;
        KW_FALS:  kw = (c == CH_E) ? KW_FALSE : KW_DEAD;
        default:  kw = KW_DEAD;
      endcase

      if (count < BIN_LEN + 1) count++;

      if (!last) return;

      // Finish the token under the mode in force now
      r.value = 32'h0;
      r.error = 1'b0;
      if (mode == MODE_TIME) begin
        r.value = dec_acc;
        r.error = !dec_ok;
      end else if (count == BIN_LEN) begin
        r.value = {16'h0000, bin_acc};
        r.error = !bin_ok;
      end else if (kw == KW_T || kw == KW_TRUE || (count == 1 && first == CH_ONE)) begin
        r.value = 32'd1;
      end else if (kw == KW_F || kw == KW_FALSE || (count == 1 && first == CH_ZERO)) begin
        r.value = 32'd0;
      end else if (first == CH_ZERO) begin
        r.value = {16'h0000, hex_acc};
        r.error = !(hex_ok && count >= 3);
      end else if (first == CH_DOLLAR) begin
        r.value = {16'h0000, hex_acc};
        r.error = !(hex_ok && count >= 2);
      end else begin
        r.value = dec_acc;
        r.error = !(dec_ok && !dec_big);
      end
      if (r.error) r.value = 32'h0;
      results_q.push_back(r);
      clear_token();
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(bit [31:0] value, bit error);
      literal_result_t e;
      if (results_q.size() == 0) begin
        $display("%0t: result with nothing expected: value=%h error=%b",
                 $time, value, error);
        errors++;
        return;
      end
      e = results_q.pop_front();
      if (e.value != value) begin
        $display("%0t: parsed value mismatch: expected %h, got %h",
                 $time, e.value, value);
        errors++;
      end
      if (e.error != error) begin
        $display("%0t: parse error flag mismatch: expected %b, got %b",
                 $time, e.error, error);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_data;

  literal_scoreboard sb;
  int                send_idle;
  int                recv_idle;
  int                chars_sent;
  int                cycle_count;
  bit [7:0]          token_q[$];

  numeric_literal_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock
  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Send one character, idling first at the current sender rate
  task automatic send_char(input bit [7:0] c, input bit last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_queued();
    for (int i = 0; i < token_q.size(); i++) send_char(token_q[i], i == token_q.size() - 1);
  endtask

  // Hold the sender until every expected result has come
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write the mode once the pipeline has emptied
  task automatic write_mode(input bit m);
    drain();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_mode(m);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [7:0] rand_case(bit [7:0] c);
    if (c >= CH_A && c <= CH_A + 8'd25 && $urandom_range(1)) return c - CASE_GAP;
    return c;
  endfunction

  // Build one random token: mostly well-formed literals, some noise
  task automatic build_token();
    string words[4] = '{"true", "t", "false", "f"};
    string hex_digits = "0123456789abcdef";
    string w;
    int    kind;
    int    len;

    token_q.delete();
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        repeat (BIN_LEN) token_q.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
        if ($urandom_range(3) == 0) token_q[$urandom_range(BIN_LEN - 1)] = 8'($urandom_range(255));
      end
      2: begin
        w = words[$urandom_range(3)];
        for (int i = 0; i < w.len(); i++) token_q.push_back(rand_case(w[i]));
        if ($urandom_range(3) == 0 && token_q.size() > 1) void'(token_q.pop_back());
        else if ($urandom_range(3) == 0) token_q.push_back(rand_case(8'(CH_A + $urandom_range(25))));
      end
      3, 4: begin
        if ($urandom_range(1)) begin
          token_q.push_back(CH_DOLLAR);
        end else begin
          token_q.push_back(CH_ZERO);
          token_q.push_back(rand_case(CH_X));
        end
        len = ($urandom_range(7) == 0) ? $urandom_range(6) : $urandom_range(1, 4);
        repeat (len) token_q.push_back(rand_case(hex_digits[$urandom_range(15)]));
      end
      5, 6: begin
        len = ($urandom_range(7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        repeat (len) token_q.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      7: begin
        token_q.push_back($urandom_range(2) == 0 ? 8'($urandom_range(255))
                                                 : 8'(CH_ZERO + $urandom_range(1)));
      end
      default: begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          if ($urandom_range(1)) token_q.push_back(8'($urandom_range(255)));
          else token_q.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
      end
    endcase
  endtask

  initial begin
    int idle_send[3];
    int idle_recv[3];
    int target;

    idle_send   = '{9, 67, 0};
    idle_recv   = '{67, 9, 0};
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = MODE_VALUE;
    send_idle   = idle_send[0];
    recv_idle   = idle_recv[0];
    chars_sent  = 0;
    cycle_count = 0;
    sb          = new();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed tokens in value mode: keywords, prefixes, limits, bad characters
    write_mode(MODE_VALUE);
    send_text("0");
    send_text("1");
    send_text("TRUE");
    send_text("t");
    send_text("False");
    send_text("F");
    send_text("trues");
    send_text("0x1F");
    send_text("$fFfF");
    send_text("0x");
    send_text("$");
    send_text("012");
    send_text("65535");
    send_text("65536");
    send_text("0x10000");
    send_text("1010101010101010");
    send_text("1210101010101010");
    send_text("12a");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);

    // Time mode: 32-bit wrap, long tokens, keywords rejected
    write_mode(MODE_TIME);
    send_text("4294967295");
    send_text("4294967296");
    send_text("99999999999999999999");
    send_text("true");

    // Mode change between characters of one token
    send_text("7000");
    send_char(CH_ZERO + 8'd7, 1'b0);
    write_mode(MODE_VALUE);
    send_text("0000");
    send_char(CH_ONE, 1'b0);
    send_char(CH_ONE + 8'd1, 1'b0);
    write_mode(MODE_TIME);
    send_text("345");

    // Random tokens under each back-pressure profile and both modes
    for (int p = 0; p < 3; p++) begin
      drain();
      send_idle = idle_send[p];
      recv_idle = idle_recv[p];
      for (int k = 0; k < 2; k++) begin
        write_mode(((k + p) % 2 == 0) ? MODE_VALUE : MODE_TIME);
        target = chars_sent + CHUNK_CHARS;
        while (chars_sent < target) begin
          build_token();
          send_queued();
          if ($urandom_range(29) == 0) drain();
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
